/* hdl/two_way_transposition_table_defines.svh */
// Assertion macros for the two-way transposition table checker.
// Uses the clk and rst_n names of the module that expands them.
`ifndef TWO_WAY_TRANSPOSITION_TABLE_DEFINES_SVH
`define TWO_WAY_TRANSPOSITION_TABLE_DEFINES_SVH

// Implication checked on the following edge, disabled in reset.
`define TWTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked on the same edge, disabled in reset.
`define TWTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/twtt_pkg.sv */
// Shared types and constants of the two-way transposition table.
// No dependencies.
package twtt_pkg;

    localparam int KEY_W    = 64;
    localparam int TAG_W    = 16;
    localparam int TAG_LSB  = 48;
    localparam int MOVE_W   = 16;
    localparam int SCORE_W  = 16;
    localparam int DEPTH_W  = 8;
    localparam int BOUND_W  = 2;
    localparam int AGE_W    = 7;

    localparam logic [AGE_W-1:0] AGE_LIMIT = 7'd127;

    // request kinds
    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    // way codes
    localparam logic WAY_DEPTH  = 1'b0;
    localparam logic WAY_ALWAYS = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
        logic [AGE_W-1:0]          age;
    } entry_t;

    typedef struct packed {
        entry_t way1;
        entry_t way0;
    } slot_t;

    typedef struct packed {
        logic                      req_type;
        logic [KEY_W-1:0]          pos_key;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
    } req_t;

    typedef struct packed {
        logic                      found;
        logic                      way;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
        logic [AGE_W-1:0]          age;
    } res_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

/* hdl/twtt_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module twtt_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];
    logic [WIDTH-1:0] rdata_reg;

    // write or registered read, one access per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/twtt_update.sv */
// Slot lookup and replacement logic: probe match and store way choice.
// Depends on twtt_pkg.
module twtt_update
    import twtt_pkg::*;
(
    input  req_t             req,
    input  slot_t            slot,
    input  logic [AGE_W-1:0] generation,
    output res_t             res,
    output logic             wr_en,
    output slot_t            wr_slot
);

    logic [TAG_W-1:0]   tag;
    logic               hit0;
    logic               hit1;
    logic               take_way0;
    logic [AGE_W-1:0]   new_age;
    logic [DEPTH_W:0]   depth_plus;
    entry_t             new_entry;

    assign tag  = req.pos_key[TAG_LSB +: TAG_W];
    assign hit0 = (slot.way0.tag == tag);
    assign hit1 = (slot.way1.tag == tag);

    // depth-preferred slot taken on deeper-or-near depth or an older age
    assign depth_plus = {1'b0, req.depth} + {{DEPTH_W{1'b0}}, 1'b1};
    assign take_way0  = (depth_plus >= {1'b0, slot.way0.depth})
                        || (generation > slot.way0.age);

    // at the age limit, the key's low bit splits the age
    assign new_age = (generation == AGE_LIMIT)
                     ? (generation - {{(AGE_W-1){1'b0}}, req.pos_key[0]})
                     : generation;

    always_comb
    begin
        new_entry.tag   = tag;
        new_entry.move  = req.move;
        new_entry.score = req.score;
        new_entry.depth = req.depth;
        new_entry.bound = req.bound;
        new_entry.age   = take_way0 ? new_age : '0;
    end

    // result and write-back
    always_comb
    begin
        res     = '0;
        wr_en   = 1'b0;
        wr_slot = slot;
        unique case (req.req_type)
            REQ_PROBE:
            begin
                if (hit0)
                begin
                    res.found = 1'b1;
                    res.way   = WAY_DEPTH;
                    res.move  = slot.way0.move;
                    res.score = slot.way0.score;
                    res.depth = slot.way0.depth;
                    res.bound = slot.way0.bound;
                    res.age   = slot.way0.age;
                end
                else if (hit1)
                begin
                    res.found = 1'b1;
                    res.way   = WAY_ALWAYS;
                    res.move  = slot.way1.move;
                    res.score = slot.way1.score;
                    res.depth = slot.way1.depth;
                    res.bound = slot.way1.bound;
                    res.age   = slot.way1.age;
                end
            end
            REQ_STORE:
            begin
                wr_en     = 1'b1;
                res.found = 1'b0;
                res.way   = take_way0 ? WAY_DEPTH : WAY_ALWAYS;
                res.move  = new_entry.move;
                res.score = new_entry.score;
                res.depth = new_entry.depth;
                res.bound = new_entry.bound;
                res.age   = new_entry.age;
                if (take_way0)
                begin
                    wr_slot.way0 = new_entry;
                end
                else
                begin
                    wr_slot.way1 = new_entry;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

/* hdl/two_way_transposition_table.sv */
// Top level of the two-way transposition table: control FSM, slot RAM, output register.
// Depends on twtt_pkg, twtt_ram and twtt_update.
//
//  channel | signals                                               | dir
//  --------+-------------------------------------------------------+----
//  in      | in_valid, in_ready, req_type, pos_key, new_* fields   | in
//  out     | out_valid, out_ready, found, entry_way, entry fields  | out
//  cfg     | cfg_valid, cfg_ready, cfg_data (search generation)    | in
//
// Each word takes a slot RAM read on accept, then compare/choose and, for a store,
// write-back in the lookup state through the same single RAM port.
// After reset a clearing pass writes zeros to all 2**SLOT_INDEX_BITS slots,
// one slot per cycle; in_ready stays low meanwhile, cfg writes are taken.
// A result waits in the output register; the next word is accepted meanwhile
// and holds in the lookup state only until that register frees up.
module two_way_transposition_table
    import twtt_pkg::*;
#(
    parameter int SLOT_INDEX_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [KEY_W-1:0]          pos_key,
    input  logic [MOVE_W-1:0]         new_move,
    input  logic signed [SCORE_W-1:0] new_score,
    input  logic [DEPTH_W-1:0]        new_depth,
    input  logic [BOUND_W-1:0]        new_bound,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic                      entry_way,
    output logic [MOVE_W-1:0]         best_move,
    output logic signed [SCORE_W-1:0] entry_score,
    output logic [DEPTH_W-1:0]        entry_depth,
    output logic [BOUND_W-1:0]        entry_bound,
    output logic [AGE_W-1:0]          entry_age,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [AGE_W-1:0]          cfg_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    state_t                     state_reg;
    logic [SLOT_INDEX_BITS-1:0] clr_addr_reg;
    logic [AGE_W-1:0]           gen_reg;
    logic                       out_valid_reg;
    req_t                       req_reg;
    res_t                       res_reg;

    logic                       in_fire;
    logic                       out_free;
    logic                       look_done;
    req_t                       req_in;
    slot_t                      rd_slot;
    res_t                       upd_res;
    logic                       upd_wr_en;
    slot_t                      upd_slot;
    logic                       ram_en;
    logic                       ram_we;
    logic [SLOT_INDEX_BITS-1:0] ram_addr;
    slot_t                      ram_wdata;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign look_done = (state_reg == S_LOOK) && out_free;

    always_comb
    begin
        req_in.req_type = req_type;
        req_in.pos_key  = pos_key;
        req_in.move     = new_move;
        req_in.score    = new_score;
        req_in.depth    = new_depth;
        req_in.bound    = new_bound;
    end

    // RAM port: clear sweep, slot read on accept, store write-back on finish
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = req_reg.pos_key[SLOT_INDEX_BITS-1:0];
        ram_wdata = upd_slot;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                ram_en   = in_fire;
                ram_addr = pos_key[SLOT_INDEX_BITS-1:0];
            end
            S_LOOK:
            begin
                ram_en = look_done && upd_wr_en;
                ram_we = 1'b1;
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    twtt_ram #(
        .WIDTH     (SLOT_W),
        .ADDR_BITS (SLOT_INDEX_BITS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_slot)
    );

    twtt_update u_update (
        .req        (req_reg),
        .slot       (rd_slot),
        .generation (gen_reg),
        .res        (upd_res),
        .wr_en      (upd_wr_en),
        .wr_slot    (upd_slot)
    );

    // control FSM, clear counter, generation register, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gen_reg <= cfg_data;
            end
            // a finished lookup refills the output register as it drains
            if (look_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + {{(SLOT_INDEX_BITS-1){1'b0}}, 1'b1};
                    if (clr_addr_reg == {SLOT_INDEX_BITS{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_in;
        end
        if (look_done)
        begin
            res_reg <= upd_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = res_reg.found;
    assign entry_way   = res_reg.way;
    assign best_move   = res_reg.move;
    assign entry_score = res_reg.score;
    assign entry_depth = res_reg.depth;
    assign entry_bound = res_reg.bound;
    assign entry_age   = res_reg.age;

endmodule

/* hdl/twtt_checker.sv */
// Port-level checker for the two-way transposition table, bound to the top level.
// Depends on two_way_transposition_table_defines.svh.
`include "two_way_transposition_table_defines.svh"

module twtt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic        entry_way,
    input logic [15:0] best_move,
    input logic [15:0] entry_score,
    input logic [7:0]  entry_depth,
    input logic [1:0]  entry_bound,
    input logic [6:0]  entry_age
);

    // a stalled result word holds
    `TWTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({found, entry_way, best_move, entry_score, entry_depth, entry_bound, entry_age}), "stalled result word changed")

    // one word in flight: no accept right after an accept
    `TWTT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input accepted while a word is in lookup")

    // a new result only follows a lookup cycle
    `TWTT_ASSERT_NOW(a_result_after_lookup, $rose(out_valid), !$past(in_ready), "result appeared without a lookup")

endmodule

bind two_way_transposition_table twtt_checker u_twtt_checker (.*);
